### design/sync_length_crc16_frame_deframer_macros.svh
// Assertion helpers for the deframer module source.
`ifndef SYNC_LENGTH_CRC16_FRAME_DEFRAMER_MACROS_SVH
`define SYNC_LENGTH_CRC16_FRAME_DEFRAMER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SLCFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer check failed");

// Next-cycle implication, checked outside reset.
`define SLCFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

### design/slcfd_pkg.sv
package slcfd_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_TOP  = 16'h8000;

  localparam logic [7:0]  SYNC_RESET = 8'd170;
  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd512;

  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;

  // Register index, taken from paddr[2].
  localparam logic REG_SYNC_VALUE  = 1'b0;
  localparam logic REG_MAX_PAYLOAD = 1'b1;

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_ACCEPTED = 2'd1,
    KIND_CRC_BAD  = 2'd2,
    KIND_TOO_LONG = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0]  sync_value;
    logic [15:0] max_payload;
  } cfg_t;

  // CRC-16/CCITT-FALSE update by one byte, MSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
    logic [15:0] crc;
    crc = crc_in ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((crc & CRC_TOP) != 16'h0000) begin
        crc = {crc[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc = {crc[14:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

### design/sync_length_crc16_frame_deframer.sv
// Byte-stream deframer: hunts for the sync byte, then reads a command byte, a
// little-endian 16-bit length, the payload and a little-endian CRC-16/CCITT-FALSE
// over command, length and payload. Every payload byte is delivered as its own
// transaction (kind 0), and the frame closes with one transaction of kind 1
// (accepted) or 2 (CRC mismatch); a length above max_payload gives kind 3 at once
// and hunting restarts. One byte is taken every clock cycle while in_stall is low,
// and its result is loaded into the output register when the byte is accepted.
// The byte-wide CRC update and the length compare lie between the parser state
// and the output register. Input stalls only while a result waits in the
// output register under stall. Registers: sync_value at byte address 0,
// max_payload at byte address 4.
`include "sync_length_crc16_frame_deframer_macros.svh"

module sync_length_crc16_frame_deframer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_data_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_kind,
  output logic [7:0]                     out_payload_byte,
  output logic [15:0]                    out_payload_index,
  output logic [7:0]                     out_frame_command,
  output logic [15:0]                    out_payload_length,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [slcfd_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [slcfd_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [slcfd_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                           cfg_pready
);

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_CMD,
    ST_LEN_LO,
    ST_LEN_HI,
    ST_PAYLOAD,
    ST_CRC_LO,
    ST_CRC_HI
  } state_t;

  slcfd_pkg::cfg_t cfg;

  state_t                   state_r, state_nxt;
  logic [15:0]              idx_r, idx_nxt;
  logic [7:0]               cmd_r, cmd_nxt;
  logic [15:0]              len_r, len_nxt;
  logic [15:0]              crc_r, crc_nxt;
  logic [7:0]               crc_lo_r, crc_lo_nxt;
  logic                     out_valid_r, out_valid_nxt;
  slcfd_pkg::kind_t         kind_r, kind_nxt;
  logic [7:0]               pbyte_r, pbyte_nxt;
  logic [15:0]              pidx_r, pidx_nxt;
  logic [7:0]               fcmd_r, fcmd_nxt;
  logic [15:0]              plen_r, plen_nxt;

  logic                     in_fire;
  logic                     res_valid;
  logic [15:0]              crc_upd;
  logic [15:0]              len_full;
  logic [15:0]              idx_inc;

  slcfd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  assign in_stall = out_valid_r & out_stall;
  assign in_fire  = in_valid & ~in_stall;
  assign crc_upd  = slcfd_pkg::crc16_byte(crc_r, in_data_byte);
  assign len_full = {in_data_byte, len_r[7:0]};
  assign idx_inc  = idx_r + 16'd1;

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    cmd_nxt    = cmd_r;
    len_nxt    = len_r;
    crc_nxt    = crc_r;
    crc_lo_nxt = crc_lo_r;
    res_valid  = 1'b0;
    kind_nxt   = kind_r;
    pbyte_nxt  = pbyte_r;
    pidx_nxt   = pidx_r;
    fcmd_nxt   = fcmd_r;
    plen_nxt   = plen_r;

    if (in_fire) begin
      case (state_r)
        ST_HUNT: begin
          if (in_data_byte == cfg.sync_value) begin
            crc_nxt   = slcfd_pkg::CRC_INIT;
            state_nxt = ST_CMD;
          end
        end
        ST_CMD: begin
          cmd_nxt   = in_data_byte;
          crc_nxt   = crc_upd;
          state_nxt = ST_LEN_LO;
        end
        ST_LEN_LO: begin
          len_nxt   = {8'h00, in_data_byte};
          crc_nxt   = crc_upd;
          state_nxt = ST_LEN_HI;
        end
        ST_LEN_HI: begin
          len_nxt = len_full;
          crc_nxt = crc_upd;
          idx_nxt = '0;
          if (len_full > cfg.max_payload) begin
            res_valid = 1'b1;
            kind_nxt  = slcfd_pkg::KIND_TOO_LONG;
            pbyte_nxt = '0;
            pidx_nxt  = '0;
            fcmd_nxt  = cmd_r;
            plen_nxt  = len_full;
            state_nxt = ST_HUNT;
          end else if (len_full == 16'h0000) begin
            state_nxt = ST_CRC_LO;
          end else begin
            state_nxt = ST_PAYLOAD;
          end
        end
        ST_PAYLOAD: begin
          crc_nxt   = crc_upd;
          idx_nxt   = idx_inc;
          res_valid = 1'b1;
          kind_nxt  = slcfd_pkg::KIND_PAYLOAD;
          pbyte_nxt = in_data_byte;
          pidx_nxt  = idx_r;
          fcmd_nxt  = cmd_r;
          plen_nxt  = len_r;
          if (idx_inc == len_r) begin
            state_nxt = ST_CRC_LO;
          end
        end
        ST_CRC_LO: begin
          crc_lo_nxt = in_data_byte;
          state_nxt  = ST_CRC_HI;
        end
        ST_CRC_HI: begin
          res_valid = 1'b1;
          kind_nxt  = ({in_data_byte, crc_lo_r} == crc_r) ? slcfd_pkg::KIND_ACCEPTED
                                                          : slcfd_pkg::KIND_CRC_BAD;
          pbyte_nxt = '0;
          pidx_nxt  = '0;
          fcmd_nxt  = cmd_r;
          plen_nxt  = len_r;
          state_nxt = ST_HUNT;
        end
        default: begin
          state_nxt = ST_HUNT;
        end
      endcase
    end

    // A new byte can only be taken when the output register is empty or draining.
    if (in_fire) begin
      out_valid_nxt = res_valid;
    end else begin
      out_valid_nxt = out_valid_r & out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_HUNT;
      idx_r       <= '0;
      cmd_r       <= '0;
      len_r       <= '0;
      crc_r       <= slcfd_pkg::CRC_INIT;
      crc_lo_r    <= '0;
      out_valid_r <= 1'b0;
      kind_r      <= slcfd_pkg::KIND_PAYLOAD;
      pbyte_r     <= '0;
      pidx_r      <= '0;
      fcmd_r      <= '0;
      plen_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      cmd_r       <= cmd_nxt;
      len_r       <= len_nxt;
      crc_r       <= crc_nxt;
      crc_lo_r    <= crc_lo_nxt;
      out_valid_r <= out_valid_nxt;
      kind_r      <= kind_nxt;
      pbyte_r     <= pbyte_nxt;
      pidx_r      <= pidx_nxt;
      fcmd_r      <= fcmd_nxt;
      plen_r      <= plen_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = kind_r;
  assign out_payload_byte   = pbyte_r;
  assign out_payload_index  = pidx_r;
  assign out_frame_command  = fcmd_r;
  assign out_payload_length = plen_r;

  `SLCFD_ASSERT_NOW(a_payload_idx_in_range, clk, rst_n, state_r == ST_PAYLOAD, idx_r < len_r)
  `SLCFD_ASSERT_NOW(a_out_idx_in_frame, clk, rst_n,
    out_valid_r && (kind_r == slcfd_pkg::KIND_PAYLOAD), pidx_r < plen_r)
  `SLCFD_ASSERT_NOW(a_status_fields_zero, clk, rst_n,
    out_valid_r && (kind_r != slcfd_pkg::KIND_PAYLOAD),
    (pbyte_r == 8'h00) && (pidx_r == 16'h0000))
  `SLCFD_ASSERT_NEXT(a_hunt_holds, clk, rst_n,
    in_fire && (state_r == ST_HUNT) && (in_data_byte != cfg.sync_value), state_r == ST_HUNT)

endmodule

### design/slcfd_regs.sv
module slcfd_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [slcfd_pkg::CFG_AW-1:0]     paddr,
  input  logic [slcfd_pkg::CFG_DW-1:0]     pwdata,
  output logic [slcfd_pkg::CFG_DW-1:0]     prdata,
  output logic                             pready,
  output slcfd_pkg::cfg_t                  cfg
);

  slcfd_pkg::cfg_t cfg_r;
  slcfd_pkg::cfg_t cfg_nxt;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (paddr[2])
        slcfd_pkg::REG_SYNC_VALUE:  cfg_nxt.sync_value  = pwdata[7:0];
        slcfd_pkg::REG_MAX_PAYLOAD: cfg_nxt.max_payload = pwdata[15:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_value  <= slcfd_pkg::SYNC_RESET;
      cfg_r.max_payload <= slcfd_pkg::MAX_PAYLOAD_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (paddr[2])
      slcfd_pkg::REG_SYNC_VALUE:  prdata = {24'h000000, cfg_r.sync_value};
      slcfd_pkg::REG_MAX_PAYLOAD: prdata = {16'h0000, cfg_r.max_payload};
      default: prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

### sim/deframer_checker.sv
package deframer_tb_pkg;
  import slcfd_pkg::*;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [15:0] index;
    logic [7:0]  command;
    logic [15:0] length;
  } deframer_result_t;

  // Bit-serial form of the CCITT polynomial update, MSB first.
  function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic [7:0]  d;
    logic        fb;
    c = crc;
    d = b;
    for (int i = 0; i < 8; i++) begin
      fb = c[15] ^ d[7];
      c = {c[14:0], 1'b0};
      d = {d[6:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

module deframer_checker
  import slcfd_pkg::*;
  import deframer_tb_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [7:0]          in_data_byte,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [1:0]          out_kind,
  input  logic [7:0]          out_payload_byte,
  input  logic [15:0]         out_payload_index,
  input  logic [7:0]          out_frame_command,
  input  logic [15:0]         out_payload_length,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CFG_AW-1:0]   cfg_paddr,
  input  logic [CFG_DW-1:0]   cfg_pwdata,
  input  logic                cfg_pready,
  output int                  fail_count,
  output int                  pending,
  output int                  payload_seen,
  output int                  accepted_seen,
  output int                  crc_bad_seen,
  output int                  too_long_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [16:0] POS_HUNT    = 17'd0;
  localparam logic [16:0] POS_CMD     = 17'd1;
  localparam logic [16:0] POS_LEN_LO  = 17'd2;
  localparam logic [16:0] POS_LEN_HI  = 17'd3;
  localparam logic [16:0] POS_PAYLOAD = 17'd4;

  logic [7:0]  sync_reg;
  logic [15:0] max_payload_reg;

  logic [16:0] pos;
  logic [7:0]  held_cmd;
  logic [15:0] held_len;
  logic [15:0] crc_acc;
  logic [7:0]  crc_lo;

  deframer_result_t expected_results[$];

  task automatic expect_result(input kind_t k, input logic [7:0] d, input logic [15:0] idx);
    deframer_result_t r;
    r.kind    = k;
    r.data    = d;
    r.index   = idx;
    r.command = held_cmd;
    r.length  = held_len;
    expected_results.push_back(r);
    pending++;
    case (k)
      KIND_PAYLOAD:  payload_seen++;
      KIND_ACCEPTED: accepted_seen++;
      KIND_CRC_BAD:  crc_bad_seen++;
      default:       too_long_seen++;
    endcase
  endtask

  task automatic advance_parser(input logic [7:0] b);
    logic [16:0] rel;
    if (pos == POS_HUNT) begin
      if (b == sync_reg) begin
        crc_acc = CRC_INIT;
        pos = POS_CMD;
      end
    end else if (pos == POS_CMD) begin
      held_cmd = b;
      crc_acc = crc16_next(crc_acc, b);
      pos = POS_LEN_LO;
    end else if (pos == POS_LEN_LO) begin
      held_len = {8'h00, b};
      crc_acc = crc16_next(crc_acc, b);
      pos = POS_LEN_HI;
    end else if (pos == POS_LEN_HI) begin
      held_len[15:8] = b;
      crc_acc = crc16_next(crc_acc, b);
      if (held_len > max_payload_reg) begin
        pos = POS_HUNT;
        expect_result(KIND_TOO_LONG, 8'h00, 16'h0000);
      end else begin
        pos = POS_PAYLOAD;
      end
    end else begin
      rel = pos - POS_PAYLOAD;
      if (rel < {1'b0, held_len}) begin
        crc_acc = crc16_next(crc_acc, b);
        pos = pos + 17'd1;
        expect_result(KIND_PAYLOAD, b, rel[15:0]);
      end else if (rel == {1'b0, held_len}) begin
        crc_lo = b;
        pos = pos + 17'd1;
      end else begin
        // The high CRC byte closes the frame whatever its value.
        pos = POS_HUNT;
        if ({b, crc_lo} == crc_acc) begin
          expect_result(KIND_ACCEPTED, 8'h00, 16'h0000);
        end else begin
          expect_result(KIND_CRC_BAD, 8'h00, 16'h0000);
        end
      end
    end
  endtask

  task automatic note_mismatch(input string what, input deframer_result_t want,
                               input deframer_result_t got);
    if (fail_count < 10) begin
      $display("%0t: %s: expected kind %0d byte %02h index %0d cmd %02h len %0d",
               $time, what, want.kind, want.data, want.index, want.command, want.length);
      $display("%0t: %s:      got kind %0d byte %02h index %0d cmd %02h len %0d",
               $time, what, got.kind, got.data, got.index, got.command, got.length);
    end
    fail_count++;
  endtask

  task automatic check_result();
    deframer_result_t got;
    deframer_result_t want;
    got.kind    = kind_t'(out_kind);
    got.data    = out_payload_byte;
    got.index   = out_payload_index;
    got.command = out_frame_command;
    got.length  = out_payload_length;
    if (expected_results.size() == 0) begin
      note_mismatch("transaction with nothing expected", '0, got);
    end else begin
      want = expected_results.pop_front();
      pending--;
      if (got.kind !== want.kind || got.data !== want.data || got.index !== want.index ||
          got.command !== want.command || got.length !== want.length) begin
        note_mismatch("result mismatch", want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      sync_reg = SYNC_RESET;
      max_payload_reg = MAX_PAYLOAD_RESET;
      pos = POS_HUNT;
      held_cmd = 8'h00;
      held_len = 16'h0000;
      crc_acc = CRC_INIT;
      crc_lo = 8'h00;
      expected_results.delete();
      pending = 0;
      fail_count = 0;
      payload_seen = 0;
      accepted_seen = 0;
      crc_bad_seen = 0;
      too_long_seen = 0;
    end else begin
      if (in_valid && !in_stall) begin
        advance_parser(in_data_byte);
      end
      if (out_valid && !out_stall) begin
        check_result();
      end
      // A register write counts from the next byte on.
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == REG_MAX_PAYLOAD) begin
          max_payload_reg = cfg_pwdata[15:0];
        end else begin
          sync_reg = cfg_pwdata[7:0];
        end
      end
    end
  end

endmodule

### sim/sync_length_crc16_frame_deframer_tb.sv
module sync_length_crc16_frame_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import slcfd_pkg::*;
  import deframer_tb_pkg::*;

  localparam int CYCLE_LIMIT      = 500000;
  localparam int SETTLE_CYCLES    = 8;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int PHASE_BYTES      = 290;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [7:0]          in_data_byte;
  logic                out_valid;
  logic                out_stall;
  logic [1:0]          out_kind;
  logic [7:0]          out_payload_byte;
  logic [15:0]         out_payload_index;
  logic [7:0]          out_frame_command;
  logic [15:0]         out_payload_length;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CFG_AW-1:0]   cfg_paddr;
  logic [CFG_DW-1:0]   cfg_pwdata;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  int fail_count;
  int pending;
  int payload_seen;
  int accepted_seen;
  int crc_bad_seen;
  int too_long_seen;

  int tx_max_gap = 0;
  int rx_max_gap = 0;
  bit rx_hold_req = 1'b0;
  int bytes_sent = 0;
  int noise_bytes = 0;
  int cycle_count = 0;

  logic [7:0]  cur_sync = SYNC_RESET;
  logic [15:0] cur_max = MAX_PAYLOAD_RESET;
  logic [7:0]  body_q[$];

  sync_length_crc16_frame_deframer i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_payload_byte   (out_payload_byte),
    .out_payload_index  (out_payload_index),
    .out_frame_command  (out_frame_command),
    .out_payload_length (out_payload_length),
    .cfg_psel           (cfg_psel),
    .cfg_penable        (cfg_penable),
    .cfg_pwrite         (cfg_pwrite),
    .cfg_paddr          (cfg_paddr),
    .cfg_pwdata         (cfg_pwdata),
    .cfg_prdata         (cfg_prdata),
    .cfg_pready         (cfg_pready)
  );

  deframer_checker i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_payload_byte   (out_payload_byte),
    .out_payload_index  (out_payload_index),
    .out_frame_command  (out_frame_command),
    .out_payload_length (out_payload_length),
    .cfg_psel           (cfg_psel),
    .cfg_penable        (cfg_penable),
    .cfg_pwrite         (cfg_pwrite),
    .cfg_paddr          (cfg_paddr),
    .cfg_pwdata         (cfg_pwdata),
    .cfg_pready         (cfg_pready),
    .fail_count         (fail_count),
    .pending            (pending),
    .payload_seen       (payload_seen),
    .accepted_seen      (accepted_seen),
    .crc_bad_seen       (crc_bad_seen),
    .too_long_seen      (too_long_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sync_length_crc16_frame_deframer_tb: FAIL");
      $finish;
    end
  end

  function automatic int draw_gap(input int max_gap);
    if (max_gap == 0 || $urandom_range(3, 0) == 0) begin
      return 0;
    end
    return $urandom_range(max_gap, 0);
  endfunction

  // Result side: a random stall before each transaction, and on request one long
  // hold-off so that the block backs up into its input.
  initial begin
    int gap;
    forever begin
      gap = draw_gap(rx_max_gap);
      @(negedge clk);
      if (rx_hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        rx_hold_req = 1'b0;
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = draw_gap(tx_max_gap);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic idle_sender();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    idle_sender();
    while (pending != 0) @(negedge clk);
    // A trailing header or CRC byte may still be in flight with no result.
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [CFG_DW-1:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic reconfigure(input logic [7:0] sync, input logic [15:0] max_len);
    wait_idle();
    cfg_write(REG_SYNC_VALUE, {24'h000000, sync});
    cfg_write(REG_MAX_PAYLOAD, {16'h0000, max_len});
    cur_sync = sync;
    cur_max = max_len;
  endtask

  // Payload bytes come from body_q first, then at random.
  task automatic send_frame(input logic [7:0] cmd, input logic [15:0] len,
                            input logic [15:0] crc_flip);
    logic [15:0] crc;
    logic [7:0]  b;
    crc = CRC_INIT;
    send_byte(cur_sync);
    send_byte(cmd);
    crc = crc16_next(crc, cmd);
    send_byte(len[7:0]);
    crc = crc16_next(crc, len[7:0]);
    send_byte(len[15:8]);
    crc = crc16_next(crc, len[15:8]);
    if (len > cur_max) begin
      body_q.delete();
      return;
    end
    for (int i = 0; i < int'(len); i++) begin
      b = (i < body_q.size()) ? body_q[i] : 8'($urandom_range(255, 0));
      send_byte(b);
      crc = crc16_next(crc, b);
    end
    body_q.delete();
    crc = crc ^ crc_flip;
    send_byte(crc[7:0]);
    send_byte(crc[15:8]);
  endtask

  task automatic random_frame();
    int          pick;
    int          room;
    logic [15:0] len;
    logic [15:0] flip;
    logic [7:0]  b;
    pick = $urandom_range(99, 0);
    if (pick < 10) begin
      // Line noise between frames, mostly clear of the sync value.
      repeat ($urandom_range(5, 1)) begin
        b = 8'($urandom_range(255, 0));
        if (b == cur_sync && $urandom_range(3, 0) != 0) begin
          b = ~b;
        end
        send_byte(b);
        noise_bytes++;
      end
    end else if (pick < 22 && cur_max != 16'hFFFF) begin
      case ($urandom_range(2, 0))
        0:       len = cur_max + 16'd1;
        1:       len = 16'hFFFF;
        default: len = 16'(int'(cur_max) + 1 + $urandom_range(16'hFFFF - cur_max - 1, 0));
      endcase
      send_frame(8'($urandom_range(255, 0)), len, 16'h0000);
    end else begin
      room = (cur_max < 16'd64) ? int'(cur_max) : 64;
      case ($urandom_range(9, 0))
        0, 1, 2, 3, 4, 5: len = 16'($urandom_range((room < 6) ? room : 6, 0));
        6, 7, 8:          len = 16'($urandom_range(room, 0));
        default:          len = 16'(room);
      endcase
      flip = (pick >= 88) ? 16'($urandom_range(65535, 1)) : 16'h0000;
      send_frame(8'($urandom_range(255, 0)), len, flip);
    end
  endtask

  task automatic run_phase(input logic [7:0] sync, input logic [15:0] max_len,
                           input int tx_gap, input int rx_gap, input int drain_every,
                           input bit long_hold);
    int start;
    int frames;
    reconfigure(sync, max_len);
    tx_max_gap = tx_gap;
    rx_max_gap = rx_gap;
    rx_hold_req = long_hold;
    start = bytes_sent - noise_bytes;
    frames = 0;
    while (bytes_sent - noise_bytes - start < PHASE_BYTES) begin
      random_frame();
      frames++;
      if (drain_every != 0 && frames % drain_every == 0) begin
        wait_idle();
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = 8'h00;
    out_stall = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed frames under the reset register values.
    tx_max_gap = 2;
    rx_max_gap = 2;
    send_byte(8'h00);
    body_q.push_back(SYNC_RESET);
    send_frame(8'h00, 16'd1, 16'h0000);
    send_frame(8'hFF, 16'd0, 16'h0000);
    send_frame(8'h5A, 16'hFFFF, 16'h0000);
    send_frame(8'hA5, MAX_PAYLOAD_RESET + 16'd1, 16'h0000);
    send_frame(8'h01, 16'd0, 16'h8000);

    run_phase(8'h55, 16'd20, 12, 12, 0, 1'b0);
    run_phase(8'h00, 16'd0, 0, 0, 0, 1'b0);
    run_phase(8'hFF, 16'hFFFF, 3, 12, 0, 1'b0);
    run_phase(8'($urandom_range(255, 0)), 16'($urandom_range(64, 1)), 0, 12, 0, 1'b1);
    run_phase(SYNC_RESET, MAX_PAYLOAD_RESET, 12, 3, 6, 1'b0);

    wait_idle();
    $display("Sent %0d bytes (%0d of them noise) over six register settings with random idle",
             bytes_sent, noise_bytes);
    $display("Checked %0d payload bytes, %0d good frames, %0d CRC errors, %0d oversize lengths",
             payload_seen, accepted_seen, crc_bad_seen, too_long_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("sync_length_crc16_frame_deframer_tb: PASS");
    end else begin
      $display("sync_length_crc16_frame_deframer_tb: FAIL");
    end
    $finish;
  end

endmodule
